FILE: sv/rbd_pkg.sv
// Shared types and codes for the ring buffer deque unit.
// Depends on nothing; every module of the unit imports it.
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

	localparam int WORD_W = 32;
	localparam int KIND_W = 3;
	localparam int STS_W  = 2;
	localparam int OCC_W  = 10;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

	// result status codes
	localparam logic [STS_W-1:0] RES_OK    = 2'd0;
	localparam logic [STS_W-1:0] RES_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] RES_FULL  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [WORD_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [STS_W-1:0]         status;
		logic signed [WORD_W-1:0] popped_value;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
		logic [OCC_W-1:0]         occupancy;
		logic                     is_empty;
	} res_item_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic exec;
		logic rd;
		logic fill;
		logic load;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_rd;
		logic out_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: sv/rbd_ctrl.sv
// Sequencing controller of the ring buffer deque unit.
// Depends on rbd_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rbd_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_stall,
	input  rbd_pkg::dp_sts_t  sts,
	output rbd_pkg::ctrl_cmd_t cmd
);
	import rbd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD,
		ST_FILL,
		ST_LOAD
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= sts.need_rd ? ST_RD : ST_LOAD;
				end
				ST_RD: begin
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					// hold until the result register is free
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd.take = (state_q == ST_IDLE) && req_valid;
		cmd.exec = (state_q == ST_EXEC);
		cmd.rd   = (state_q == ST_RD);
		cmd.fill = (state_q == ST_FILL);
		cmd.load = (state_q == ST_LOAD) && !sts.out_busy;
	end

endmodule

`default_nettype wire

FILE: sv/rbd_dpath.sv
// Datapath of the ring buffer deque unit: pointers, ring store,
// cached end words and the result register. Depends on rbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbd_dpath #(
	parameter int DEPTH = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  rbd_pkg::req_item_t  req_data,
	input  rbd_pkg::ctrl_cmd_t  cmd,
	output rbd_pkg::dp_sts_t    sts,
	output rbd_pkg::res_item_t  res_data,
	output logic                res_valid,
	input  wire                 res_stall
);
	import rbd_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [PW:0]   DEPTH_X = (PW + 1)'(DEPTH);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == LAST) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		ptr_dec = (p == '0) ? LAST : p - PW'(1);
	endfunction

	logic signed [WORD_W-1:0] mem [DEPTH];

	req_item_t                item_q;
	logic [PW-1:0]            head_q;
	logic [PW-1:0]            tail_q;
	logic signed [WORD_W-1:0] front_q;
	logic signed [WORD_W-1:0] back_q;
	logic signed [WORD_W-1:0] popped_q;
	logic [STS_W-1:0]         status_q;
	logic signed [WORD_W-1:0] rdata_q;
	res_item_t                res_q;
	logic                     res_valid_q;

	logic          empty;
	logic          full;
	logic [PW-1:0] head_inc;
	logic [PW-1:0] head_dec;
	logic [PW-1:0] tail_inc;
	logic [PW-1:0] tail_dec;
	logic          we;
	logic [PW-1:0] waddr;
	logic [PW-1:0] raddr;
	logic [PW:0]   occ;

	always_comb begin
		head_inc = ptr_inc(head_q);
		head_dec = ptr_dec(head_q);
		tail_inc = ptr_inc(tail_q);
		tail_dec = ptr_dec(tail_q);
		empty    = (head_q == tail_q);
		full     = (tail_inc == head_q);
	end

	// a pop that leaves words behind needs the new end word from the store
	always_comb begin
		case (item_q.kind)
			KIND_POP_FRONT: sts.need_rd = !empty && (head_inc != tail_q);
			KIND_POP_BACK:  sts.need_rd = !empty && (tail_dec != head_q);
			default:        sts.need_rd = 1'b0;
		endcase
		sts.out_busy = res_valid_q && res_stall;
	end

	always_comb begin
		we    = 1'b0;
		waddr = tail_inc;
		if (cmd.exec && !full) begin
			case (item_q.kind)
				KIND_PUSH_BACK: begin
					we    = 1'b1;
					waddr = tail_inc;
				end
				KIND_PUSH_FRONT: begin
					we    = 1'b1;
					waddr = head_q;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
		// pointers already moved by the time of the read
		raddr = (item_q.kind == KIND_POP_FRONT) ? head_inc : tail_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= item_q.value;
		if (cmd.rd) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) item_q <= req_data;
		if (cmd.exec) begin
			status_q <= RES_OK;
			popped_q <= '0;
			case (item_q.kind) inside
				KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
					if (full) status_q <= RES_FULL;
				end
				KIND_POP_FRONT: begin
					if (empty) status_q <= RES_EMPTY;
					else popped_q <= front_q;
				end
				KIND_POP_BACK: begin
					if (empty) status_q <= RES_EMPTY;
					else popped_q <= back_q;
				end
				default: begin
					status_q <= RES_OK;
				end
			endcase
		end
		if (cmd.load) begin
			res_q.status       <= status_q;
			res_q.popped_value <= popped_q;
			res_q.front_value  <= front_q;
			res_q.back_value   <= back_q;
			res_q.occupancy    <= OCC_W'(occ);
			res_q.is_empty     <= empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			front_q <= '0;
			back_q  <= '0;
		end else if (cmd.exec) begin
			case (item_q.kind)
				KIND_PUSH_BACK: begin
					if (!full) begin
						tail_q <= tail_inc;
						back_q <= item_q.value;
						if (empty) front_q <= item_q.value;
					end
				end
				KIND_PUSH_FRONT: begin
					if (!full) begin
						head_q  <= head_dec;
						front_q <= item_q.value;
						if (empty) back_q <= item_q.value;
					end
				end
				KIND_POP_FRONT: begin
					if (!empty) begin
						head_q <= head_inc;
						if (head_inc == tail_q) begin
							front_q <= '0;
							back_q  <= '0;
						end
					end
				end
				KIND_POP_BACK: begin
					if (!empty) begin
						tail_q <= tail_dec;
						if (tail_dec == head_q) begin
							front_q <= '0;
							back_q  <= '0;
						end
					end
				end
				default: begin
					head_q <= head_q;
				end
			endcase
		end else if (cmd.fill) begin
			if (item_q.kind == KIND_POP_FRONT) front_q <= rdata_q;
			else back_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		if (tail_q >= head_q) occ = {1'b0, tail_q} - {1'b0, head_q};
		else occ = {1'b0, tail_q} + DEPTH_X - {1'b0, head_q};
	end

	assign res_data  = res_q;
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

FILE: sv/ring_buffer_deque_unit.sv
// Top level of the ring buffer deque unit: controller plus datapath.
// Depends on rbd_pkg, rbd_ctrl and rbd_dpath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   request  | req_valid, req_stall | req_data (kind, value)
//   result   | res_valid, res_stall | res_data (status, words, count)
//
// One request is in work at a time. A push, a query or a pop that leaves
// the deque empty steps through accept, execute and load result; a pop that
// leaves words adds a store read and a fill, as the new end word comes through the registered read.
// The next request is taken the cycle after the load, while that result waits.
// A stalled result holds the load step until the result register frees.
// Reset clears the pointers and cached end words, not the store.
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_deque_unit #(
	parameter int DEPTH = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  rbd_pkg::req_item_t  req_data,
	output logic                res_valid,
	input  wire                 res_stall,
	output rbd_pkg::res_item_t  res_data
);
	import rbd_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// sequence each request: take, execute, optional store read and fill, load
	rbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// pointers, ring store and result register
	rbd_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_data  (res_data),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

`ifndef SYNTHESIS
	// a new result only appears after a load step
	a_res_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd.load))
		else $error("result raised without a load");

	// never overwrite a result that is still waiting
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(res_valid && res_stall))
		else $error("load while result stalled");

	// one request in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second request taken while busy");

	// an empty deque reports zero end words
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.is_empty) |->
		(res_data.front_value == '0 && res_data.back_value == '0))
		else $error("empty result with nonzero end words");
`endif

endmodule

`default_nettype wire

FILE: test/ring_buffer_deque_unit_tb.sv
// Self-checking bench for ring_buffer_deque_unit: sends deque requests with random idling
// on both channels, predicts every result from an in-bench mirror of the deque.
// Depends on rbd_pkg and the ring_buffer_deque_unit RTL.
`timescale 1ns / 1ps

module ring_buffer_deque_unit_tb;
	import rbd_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int END_SETTLE = 20;
	localparam int HOLD_LEN   = 300;

	// kinds the block treats as a plain query
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

	typedef logic [PTR_W-1:0] slot_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req_data  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_data;

	// Mirror of the deque: ring, head (free slot before the front), tail (back word).
	logic [WORD_W-1:0] mirror_ring [0:DEPTH-1];
	slot_t             mirror_head = '0;
	slot_t             mirror_tail = '0;

	// Results still owed by the block, oldest first.
	res_item_t op_outcomes [$];

	bit sender_quiet   = 1'b0;
	bit receiver_quiet = 1'b0;
	int hold_request   = 0;

	int mismatches    = 0;
	int requests_sent = 0;
	int results_seen  = 0;
	int full_refusals = 0;
	int empty_pops    = 0;
	int peak_count    = 0;

	ring_buffer_deque_unit #(
		.DEPTH(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit mirror_full();
		slot_t after_tail;
		after_tail = mirror_tail + 1'b1;
		return after_tail == mirror_head;
	endfunction

	// Apply one request to the mirror and return the result it must produce.
	function automatic res_item_t apply_deque_op(req_item_t rq);
		res_item_t r;
		slot_t     after_tail;
		slot_t     front_slot;
		slot_t     span;
		bit        was_empty;
		bit        was_full;
		r          = '0;
		r.status   = RES_OK;
		after_tail = mirror_tail + 1'b1;
		was_empty  = (mirror_head == mirror_tail);
		was_full   = mirror_full();
		case (rq.kind)
		KIND_PUSH_BACK: begin
			if (was_full) begin
				r.status = RES_FULL;
			end else begin
				mirror_tail              = after_tail;
				mirror_ring[mirror_tail] = rq.value;
			end
		end
		KIND_PUSH_FRONT: begin
			if (was_full) begin
				r.status = RES_FULL;
			end else begin
				mirror_ring[mirror_head] = rq.value;
				mirror_head              = mirror_head - 1'b1;
			end
		end
		KIND_POP_FRONT: begin
			if (was_empty) begin
				r.status = RES_EMPTY;
			end else begin
				mirror_head    = mirror_head + 1'b1;
				r.popped_value = mirror_ring[mirror_head];
			end
		end
		KIND_POP_BACK: begin
			if (was_empty) begin
				r.status = RES_EMPTY;
			end else begin
				r.popped_value = mirror_ring[mirror_tail];
				mirror_tail    = mirror_tail - 1'b1;
			end
		end
		default: begin
		end
		endcase

		// Report the deque as it stands after the step; end words read zero when empty.
		span        = mirror_tail - mirror_head;
		r.occupancy = span;
		r.is_empty  = (mirror_head == mirror_tail);
		if (!r.is_empty) begin
			front_slot    = mirror_head + 1'b1;
			r.front_value = mirror_ring[front_slot];
			r.back_value  = mirror_ring[mirror_tail];
		end

		if (r.status == RES_FULL)
			full_refusals++;
		if (r.status == RES_EMPTY)
			empty_pops++;
		if (int'(span) > peak_count)
			peak_count = int'(span);
		return r;
	endfunction

	// Idle length between requests: mostly none or short, now and then long.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one request, hold it until accepted, then record what it must return.
	task automatic issue_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value);
		req_item_t item;
		res_item_t expected;
		int        gap;
		item.kind  = kind;
		item.value = value;
		gap        = sender_quiet ? 0 : idle_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		expected = apply_deque_op(item);
		op_outcomes.insert(op_outcomes.size(), expected);
		requests_sent++;
	endtask

	// Drop valid and wait until every owed result has come back.
	task automatic pause_until_drained();
		req_valid <= 1'b0;
		while (op_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic issue_random_push();
		issue_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, $urandom);
	endtask

	task automatic issue_random_pop();
		issue_op($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK, $urandom);
	endtask

	task automatic issue_random_query();
		logic [KIND_W-1:0] k;
		k = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
		if ($urandom_range(0, 1))
			k = KIND_QUERY;
		issue_op(k, $urandom);
	endtask

	// Query and pop an empty deque, including the spare kinds.
	task automatic test_empty_deque();
		logic [KIND_W-1:0] k;
		issue_op(KIND_QUERY, 32'h0000_0000);
		issue_op(KIND_POP_FRONT, 32'hFFFF_FFFF);
		issue_op(KIND_POP_BACK, 32'h8000_0000);
		for (k = KIND_SPARE_LO; k != KIND_SPARE_HI; k++)
			issue_op(k, 32'h7FFF_FFFF);
		issue_op(KIND_SPARE_HI, 32'h1234_5678);
	endtask

	// Extreme words through both ends; the first front push wraps the head below zero.
	task automatic test_end_words();
		issue_op(KIND_PUSH_BACK, 32'h7FFF_FFFF);
		issue_op(KIND_PUSH_FRONT, 32'h8000_0000);
		issue_op(KIND_PUSH_BACK, 32'h0000_0000);
		issue_op(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
		issue_op(KIND_QUERY, 32'h0000_0000);
		issue_op(KIND_POP_FRONT, 32'h0000_0000);
		issue_op(KIND_POP_BACK, 32'h0000_0000);
		issue_op(KIND_POP_FRONT, 32'h0000_0000);
		issue_op(KIND_POP_BACK, 32'h0000_0000);
		issue_op(KIND_POP_BACK, 32'h0000_0000);
		issue_op(KIND_PUSH_BACK, 32'hAAAA_AAAA);
		issue_op(KIND_PUSH_FRONT, 32'h5555_5555);
		issue_op(KIND_POP_BACK, 32'h0000_0000);
		issue_op(KIND_POP_BACK, 32'h0000_0000);
		issue_op(KIND_SPARE_LO + 3'd1, 32'hDEAD_BEEF);
	endtask

	// Grow the deque to capacity with random words, then push into the full deque.
	// Along the way: a burst with no idling, and a long receiver hold while the
	// sender keeps offering, so the block backs up and stalls its request side.
	task automatic test_fill_to_full();
		int n;
		int r;
		int extra;
		n              = 0;
		extra          = 0;
		sender_quiet   = 1'b1;
		receiver_quiet = 1'b1;
		while (extra < 6) begin
			if (n == 150) begin
				sender_quiet   = 1'b0;
				receiver_quiet = 1'b0;
			end
			if (n == 300) begin
				sender_quiet = 1'b1;
				hold_request = HOLD_LEN;
			end
			if (n == 420)
				sender_quiet = 1'b0;
			if (mirror_full())
				extra++;
			r = $urandom_range(0, 99);
			if (extra > 0 || r < 96)
				issue_random_push();
			else if (r < 99)
				issue_random_pop();
			else
				issue_random_query();
			n++;
		end
		// Hold the sender back until the full-deque results are all in.
		pause_until_drained();
	endtask

	// Mixed traffic from the full deque, weighted toward pops.
	task automatic test_mixed_churn();
		int i;
		int r;
		for (i = 0; i < 140; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				issue_random_pop();
			else if (r < 85)
				issue_random_push();
			else
				issue_random_query();
		end
	endtask

	// Result side: random stall runs, or a long hold when a test asks for one.
	initial begin : result_receiver
		int   stall_left;
		int   r;
		logic stall_now;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				stall_now = 1'b1;
				stall_left--;
			end else if (receiver_quiet) begin
				stall_now = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75)
					stall_left = 0;
				else if (r < 93)
					stall_left = $urandom_range(1, 3);
				else if (r < 99)
					stall_left = $urandom_range(4, 10);
				else
					stall_left = $urandom_range(20, 50);
				stall_now = (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
			res_stall <= stall_now;
		end
	end

	// Compare each accepted result with the oldest owed one, field by field.
	initial begin : result_checker
		res_item_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				results_seen++;
				if (op_outcomes.size() == 0) begin
					$error("result with no request awaiting it: status %0d occupancy %0d",
						res_data.status, res_data.occupancy);
					mismatches++;
				end else begin
					want = op_outcomes[0];
					op_outcomes.delete(0);
					if (res_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res_data.status);
						mismatches++;
					end
					if (res_data.popped_value !== want.popped_value) begin
						$error("popped_value: expected %0d, got %0d",
							want.popped_value, res_data.popped_value);
						mismatches++;
					end
					if (res_data.front_value !== want.front_value) begin
						$error("front_value: expected %0d, got %0d",
							want.front_value, res_data.front_value);
						mismatches++;
					end
					if (res_data.back_value !== want.back_value) begin
						$error("back_value: expected %0d, got %0d",
							want.back_value, res_data.back_value);
						mismatches++;
					end
					if (res_data.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d",
							want.occupancy, res_data.occupancy);
						mismatches++;
					end
					if (res_data.is_empty !== want.is_empty) begin
						$error("is_empty: expected %0d, got %0d",
							want.is_empty, res_data.is_empty);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_deque();
		test_end_words();
		test_fill_to_full();
		test_mixed_churn();

		// Let the last results come home, then give the block time to misbehave.
		pause_until_drained();
		repeat (END_SETTLE) @(posedge clk);

		$display("Covered %0d requests and %0d results; deque reached %0d of %0d words.",
			requests_sent, results_seen, peak_count, DEPTH - 1);
		$display("Pushes refused on a full deque: %0d; pops on an empty deque: %0d.",
			full_refusals, empty_pops);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
